FILE: hdl/sbfsu_pkg.sv
// shared types and constants for the sbus frame sync and unpack block
`timescale 1ns / 1ps

package sbfsu_pkg;

  localparam int WIN_LEN   = 25;
  localparam int PAY_BYTES = 23;
  localparam int PAY_W     = PAY_BYTES * 8;
  localparam int CHAN_BITS = 11;
  localparam int NUM_CHAN  = 16;
  localparam int CHAN_VEC_W = NUM_CHAN * CHAN_BITS;

  localparam logic [7:0] START_BYTE  = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;
  localparam logic [7:0] LIMIT_RESET = 8'd50;

  localparam logic [4:0] FLAG_HI_IDX = 5'd16;
  localparam logic [4:0] LAST_IDX    = 5'd17;
  localparam logic [4:0] ANALOG_END  = 5'd16;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic {
    KIND_FRAME,
    KIND_TIMEOUT
  } kind_t;

  // bytes 1 to 23 of the matched window, byte 1 in the lowest bits
  typedef struct packed {
    kind_t              kind;
    logic [PAY_W-1:0]   payload;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/sbfsu_front.sv
// front end: byte window, frame and timeout detection, queue push
`timescale 1ns / 1ps

module sbfsu_front import sbfsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // rx_byte[7:0]
  input  q_status_t  q_stat,
  output logic       push,
  output q_entry_t   push_entry
);

  logic [7:0] win [WIN_LEN];
  logic [7:0] search_limit;
  logic [7:0] search_count;
  logic [8:0] count_inc;
  logic       accept;
  logic       frame_hit;
  logic       limit_hit;

  assign s_tready  = !q_stat.full;
  assign accept    = s_tvalid && s_tready;
  assign count_inc = {1'b0, search_count} + 9'd1;
  // after the shift, position 0 holds what sits at position 1 now
  assign frame_hit = (win[1] == START_BYTE) && (s_tdata == END_BYTE);
  assign limit_hit = count_inc >= {1'b0, search_limit};
  assign push      = accept && (frame_hit || limit_hit);

  always_comb begin
    push_entry.kind = frame_hit ? KIND_FRAME : KIND_TIMEOUT;
    for (int j = 0; j < PAY_BYTES; j++) begin
      push_entry.payload[8*j +: 8] = win[j+2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= LIMIT_RESET;
      search_count <= '0;
      for (int i = 0; i < WIN_LEN; i++) win[i] <= '0;
    end else begin
      if (cfg_we) search_limit <= cfg_wdata;
      if (accept) begin
        if (push) begin
          search_count <= '0;
          for (int i = 0; i < WIN_LEN; i++) win[i] <= '0;
        end else begin
          search_count <= count_inc[7:0];
          for (int i = 0; i < WIN_LEN-1; i++) win[i] <= win[i+1];
          win[WIN_LEN-1] <= s_tdata;
        end
      end
    end
  end

endmodule

FILE: hdl/sbfsu_queue.sv
// small queue of matched frames and timeouts between front and back
`timescale 1ns / 1ps

module sbfsu_queue import sbfsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t q_stat
);

  q_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (fill == Q_DEPTH[Q_AW:0]);
  assign q_stat.empty = (fill == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hdl/sbfsu_back.sv
// back end: walks one queued entry into results, registered output
`timescale 1ns / 1ps

module sbfsu_back import sbfsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    head,
  input  q_status_t   q_stat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // channel_index[4:0], channel_value[10:0]
  output logic        m_tuser,   // timeout
  output logic        m_tlast    // last
);

  logic                  busy;
  logic [4:0]            cnt;
  logic                  cur_tmo;
  logic [CHAN_VEC_W-1:0] sr;
  logic [1:0]            flags;
  logic                  advance;
  logic                  finishing;
  logic [4:0]            res_index;
  logic [10:0]           res_value;

  assign advance   = !m_tvalid || m_tready;
  assign finishing = cur_tmo || (cnt == LAST_IDX);
  assign pop       = !q_stat.empty && (!busy || (advance && finishing));

  always_comb begin
    if (cur_tmo) begin
      res_index = '0;
      res_value = '0;
    end else begin
      res_index = cnt;
      if (cnt < ANALOG_END) begin
        res_value = sr[CHAN_BITS-1:0];
      end else if (cnt == FLAG_HI_IDX) begin
        res_value = {10'd0, flags[1]};
      end else begin
        res_value = {10'd0, flags[0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) m_tvalid <= busy;
      if (pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (advance && busy) begin
        if (finishing) busy <= 1'b0;
        else           cnt  <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      m_tdata <= {res_value, res_index};
      m_tuser <= cur_tmo;
      m_tlast <= finishing;
    end
    if (pop) begin
      cur_tmo <= (head.kind == KIND_TIMEOUT);
      sr      <= head.payload[CHAN_VEC_W-1:0];
      // bit 7 and bit 6 of byte 23
      flags   <= head.payload[PAY_W-1 -: 2];
    end else if (advance && busy) begin
      sr <= sr >> CHAN_BITS;
    end
  end

endmodule

FILE: hdl/sbus_frame_sync_unpack.sv
// top level of the sbus frame sync and unpack block
`timescale 1ns / 1ps

// Takes one serial byte per cycle on the slave stream while s_tready is high
// and keeps a 25-byte window. A frame (0x0F oldest, 0x00 newest) yields 18
// results: channels 0 to 15 with their 11-bit values, then the two flags as
// channels 16 and 17, tlast on the last. A search that runs search_limit bytes
// without a frame yields one result with tuser (timeout) and tlast set. Bytes
// are taken as long as the 4-entry event queue between the detector and the
// unpacker has room; s_tready drops only while that queue is full. The unpacker
// sends one result per cycle while m_tready is high; a result passes through the
// event queue and the unpacker's output register. cfg_we writes search_limit
// (reset 50).
module sbus_frame_sync_unpack import sbfsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // channel_index[4:0], channel_value[10:0]
  output logic        m_tuser,   // timeout
  output logic        m_tlast    // last
);

  q_status_t q_stat;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  sbfsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  sbfsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sbfsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: hdl/sbfsu_checker.sv
// port-level checks for the sbus frame sync and unpack block
`timescale 1ns / 1ps

module sbfsu_checker import sbfsu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // timeout result is a lone last item with zero index and value
  a_tmo: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 16'h0000))
    else $error("malformed timeout result");

  // a frame ends exactly on the second flag channel
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast == (m_tdata[4:0] == LAST_IDX))
    else $error("frame last misplaced");

  // flag channels carry one bit
  a_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && ((m_tdata[4:0] == FLAG_HI_IDX) || (m_tdata[4:0] == LAST_IDX))
      |-> (m_tdata[15:6] == 10'd0))
    else $error("flag value wider than one bit");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sbus_frame_sync_unpack sbfsu_checker u_chk (.*);
